[design/phd_pkg.sv]
// Shared constants, command and job codes, and job type of the pair-distance histogram.
`default_nettype none

package phd_pkg;

    localparam int NUM_BINS    = 1024;
    localparam int BIN_W       = $clog2(NUM_BINS);
    localparam int QUEUE_DEPTH = 2;

    localparam int CMD_W      = 2;
    localparam int DIST_W     = 16;
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 32;
    localparam int SCALE_W    = 16;
    localparam int BIU_W      = 11;
    localparam int CMP_W      = DIST_W + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd25600;
    localparam logic [BIU_W-1:0]   BIU_RESET   = 11'd700;

    localparam logic [CFG_IDX_W-1:0] CFG_BIN_SCALE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = 1'd1;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_BIN   = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD_OVF   = 3'd2;
    localparam logic [OP_W-1:0] OP_SAMPLE    = 3'd3;
    localparam logic [OP_W-1:0] OP_READ      = 3'd4;
    localparam logic [OP_W-1:0] OP_READ_ZERO = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [BIN_W-1:0] addr;
    } phd_job_t;

endpackage

`default_nettype wire

[design/phd_if.sv]
// Request and result channel interfaces of the pair-distance histogram.
`default_nettype none

interface phd_req_if;
    logic                        valid;
    logic                        ready;
    logic [phd_pkg::CMD_W-1:0]   cmd;
    logic [phd_pkg::DIST_W-1:0]  distance;
    logic [phd_pkg::IDX_W-1:0]   bin_index;

    modport source (output valid, cmd, distance, bin_index, input ready);
    modport sink   (input valid, cmd, distance, bin_index, output ready);
endinterface

interface phd_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [phd_pkg::CNT_W-1:0]   bin_count;
    logic [phd_pkg::CNT_W-1:0]   overflow_count;
    logic [phd_pkg::CNT_W-1:0]   sample_count;

    modport source (output valid, bin_count, overflow_count, sample_count, input ready);
    modport sink   (input valid, bin_count, overflow_count, sample_count, output ready);
endinterface

`default_nettype wire

[design/phd_front.sv]
// Front end: configuration registers, request intake and bin classification.
`default_nettype none

module phd_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    phd_req_if.sink                               req,
    input  wire logic                             cfg_we,
    input  wire logic [phd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [phd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                             init_busy,
    input  wire logic                             queue_full,
    output logic                                  push,
    output phd_pkg::phd_job_t                     job
);

    logic [phd_pkg::SCALE_W-1:0]                  scale_reg;
    logic [phd_pkg::BIU_W-1:0]                    biu_reg;
    logic [phd_pkg::DIST_W+phd_pkg::SCALE_W-1:0]  prod;
    logic [phd_pkg::DIST_W-1:0]                   bin;
    logic                                         bin_hit;
    logic                                         read_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= phd_pkg::SCALE_RESET;
            biu_reg   <= phd_pkg::BIU_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                phd_pkg::CFG_BIN_SCALE:   scale_reg <= cfg_wdata[phd_pkg::SCALE_W-1:0];
                phd_pkg::CFG_BINS_IN_USE: biu_reg   <= cfg_wdata[phd_pkg::BIU_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Q8.8 times Q8.8 gives Q16.16; the bin is the integer part
    assign prod = req.distance * scale_reg;
    assign bin  = prod[phd_pkg::DIST_W+phd_pkg::SCALE_W-1:phd_pkg::SCALE_W];

    assign bin_hit = ({1'b0, bin} < phd_pkg::CMP_W'(biu_reg))
                  && ({1'b0, bin} < phd_pkg::CMP_W'(phd_pkg::NUM_BINS));
    assign read_ok = phd_pkg::CMP_W'(req.bin_index) < phd_pkg::CMP_W'(phd_pkg::NUM_BINS);

    always_comb
    begin
        job.addr = '0;
        case (req.cmd)
            phd_pkg::CMD_CLEAR:
            begin
                job.op = phd_pkg::OP_CLEAR;
            end
            phd_pkg::CMD_ADD:
            begin
                job.op   = bin_hit ? phd_pkg::OP_ADD_BIN : phd_pkg::OP_ADD_OVF;
                job.addr = phd_pkg::BIN_W'(bin);
            end
            phd_pkg::CMD_SAMPLE:
            begin
                job.op = phd_pkg::OP_SAMPLE;
            end
            default: // read
            begin
                job.op   = read_ok ? phd_pkg::OP_READ : phd_pkg::OP_READ_ZERO;
                job.addr = phd_pkg::BIN_W'(req.bin_index);
            end
        endcase
    end

    assign req.ready = !queue_full && !init_busy;
    assign push      = req.valid && req.ready;

endmodule

`default_nettype wire

[design/phd_queue.sv]
// Short job queue between the front end and the histogram engine.
`default_nettype none

module phd_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire phd_pkg::phd_job_t   push_job,
    input  wire logic                pop,
    output logic                     full,
    output logic                     empty,
    output phd_pkg::phd_job_t        head
);

    localparam int QP_W = $clog2(phd_pkg::QUEUE_DEPTH);
    localparam int QC_W = $clog2(phd_pkg::QUEUE_DEPTH + 1);

    phd_pkg::phd_job_t slot_reg [phd_pkg::QUEUE_DEPTH];
    logic [QP_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0]   count_reg, count_next;

    assign full  = count_reg == QC_W'(phd_pkg::QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QP_W'(phd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QP_W'(phd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

[design/phd_back.sv]
// Histogram engine: count memory, read-modify-write, counters, clear sweep, result register.
`default_nettype none

module phd_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               queue_empty,
    input  wire phd_pkg::phd_job_t  head,
    output logic                    pop,
    output logic                    init_busy,
    phd_rsp_if.source               rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RMW  = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_CLR  = 2'd3;

    localparam logic [phd_pkg::CNT_W-1:0] CNT_MAX = {phd_pkg::CNT_W{1'b1}};

    function automatic logic [phd_pkg::CNT_W-1:0] sat_inc(input logic [phd_pkg::CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    logic [phd_pkg::CNT_W-1:0] mem [phd_pkg::NUM_BINS];

    logic [1:0]                 state_reg, state_next;
    logic [phd_pkg::BIN_W-1:0]  sweep_reg, sweep_next;
    logic [phd_pkg::BIN_W-1:0]  addr_reg, addr_next;
    logic                       report_reg, report_next;
    logic [phd_pkg::CNT_W-1:0]  ovf_reg, ovf_next;
    logic [phd_pkg::CNT_W-1:0]  smp_reg, smp_next;
    logic [phd_pkg::CNT_W-1:0]  rdata_reg;

    logic                       out_valid_reg, out_valid_next;
    logic [phd_pkg::CNT_W-1:0]  out_bin_reg, out_bin_next;
    logic [phd_pkg::CNT_W-1:0]  out_ovf_reg, out_ovf_next;
    logic [phd_pkg::CNT_W-1:0]  out_smp_reg, out_smp_next;

    logic                       room;
    logic                       mem_re;
    logic [phd_pkg::BIN_W-1:0]  mem_raddr;
    logic                       mem_we;
    logic [phd_pkg::BIN_W-1:0]  mem_waddr;
    logic [phd_pkg::CNT_W-1:0]  mem_wdata;

    // a job is only taken when the result register is free by the next edge
    assign room      = !out_valid_reg || rsp.ready;
    assign init_busy = (state_reg == S_CLR) && !report_reg;
    assign mem_raddr = head.addr;

    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        addr_next      = addr_reg;
        report_next    = report_reg;
        ovf_next       = ovf_reg;
        smp_next       = smp_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_bin_next   = out_bin_reg;
        out_ovf_next   = out_ovf_reg;
        out_smp_next   = out_smp_reg;
        pop            = 1'b0;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = sweep_reg;
        mem_wdata      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (!queue_empty && room)
                begin
                    pop = 1'b1;
                    case (head.op)
                        phd_pkg::OP_CLEAR:
                        begin
                            ovf_next    = '0;
                            smp_next    = '0;
                            sweep_next  = '0;
                            report_next = 1'b1;
                            state_next  = S_CLR;
                        end
                        phd_pkg::OP_ADD_BIN:
                        begin
                            mem_re     = 1'b1;
                            addr_next  = head.addr;
                            state_next = S_RMW;
                        end
                        phd_pkg::OP_READ:
                        begin
                            mem_re     = 1'b1;
                            state_next = S_RD;
                        end
                        phd_pkg::OP_ADD_OVF:
                        begin
                            ovf_next       = sat_inc(ovf_reg);
                            out_valid_next = 1'b1;
                            out_bin_next   = '0;
                            out_ovf_next   = sat_inc(ovf_reg);
                            out_smp_next   = smp_reg;
                        end
                        phd_pkg::OP_SAMPLE:
                        begin
                            smp_next       = sat_inc(smp_reg);
                            out_valid_next = 1'b1;
                            out_bin_next   = '0;
                            out_ovf_next   = ovf_reg;
                            out_smp_next   = sat_inc(smp_reg);
                        end
                        default: // read beyond capacity
                        begin
                            out_valid_next = 1'b1;
                            out_bin_next   = '0;
                            out_ovf_next   = ovf_reg;
                            out_smp_next   = smp_reg;
                        end
                    endcase
                end
            end
            S_RMW:
            begin
                mem_we         = 1'b1;
                mem_waddr      = addr_reg;
                mem_wdata      = sat_inc(rdata_reg);
                out_valid_next = 1'b1;
                out_bin_next   = '0;
                out_ovf_next   = ovf_reg;
                out_smp_next   = smp_reg;
                state_next     = S_IDLE;
            end
            S_RD:
            begin
                out_valid_next = 1'b1;
                out_bin_next   = rdata_reg;
                out_ovf_next   = ovf_reg;
                out_smp_next   = smp_reg;
                state_next     = S_IDLE;
            end
            default: // S_CLR: one entry per cycle
            begin
                mem_we = 1'b1;
                if (sweep_reg == phd_pkg::BIN_W'(phd_pkg::NUM_BINS - 1))
                begin
                    sweep_next  = '0;
                    state_next  = S_IDLE;
                    report_next = 1'b0;
                    if (report_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_bin_next   = '0;
                        out_ovf_next   = '0;
                        out_smp_next   = '0;
                    end
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            sweep_reg     <= '0;
            report_reg    <= 1'b0;
            ovf_reg       <= '0;
            smp_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            report_reg    <= report_next;
            ovf_reg       <= ovf_next;
            smp_reg       <= smp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        out_bin_reg <= out_bin_next;
        out_ovf_reg <= out_ovf_next;
        out_smp_reg <= out_smp_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.bin_count      = out_bin_reg;
    assign rsp.overflow_count = out_ovf_reg;
    assign rsp.sample_count   = out_smp_reg;

    a_pop_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> room)
        else $error("job taken while result register stays occupied");

    a_rmw_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RMW || state_reg == S_RD) |-> $past(state_reg) == S_IDLE)
        else $error("memory access state not entered from idle");

    a_clear_counters: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> (ovf_reg == '0 && smp_reg == '0))
        else $error("counters nonzero during clear sweep");

    a_sweep_parked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CLR) |-> (sweep_reg == '0))
        else $error("sweep counter moved outside clear sweep");

    a_no_result_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(init_busy) && init_busy) |-> !rsp.valid)
        else $error("result presented during power-on clear");

endmodule

`default_nettype wire

[design/pair_distance_histogram.sv]
// Top level of the pair-distance histogram accumulator.
//
//  channel  | dir | payload                                     | accepted when
//  req      | in  | cmd, distance, bin_index                    | req.valid & req.ready
//  rsp      | out | bin_count, overflow_count, sample_count     | rsp.valid & rsp.ready
//  cfg      | in  | cfg_index (0 bin_scale, 1 bins_in_use)      | cfg_we
//
// Sample, overflow add and out-of-range read are answered straight from idle;
// bin add and bin read first read the count memory, then write back or respond.
// Clear sweeps the count memory one bin per cycle.
// After reset the same sweep runs with req.ready low.
// A 2-deep job queue keeps taking requests while a result waits on rsp.ready.
`default_nettype none

module pair_distance_histogram (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    phd_req_if.sink                               req,
    phd_rsp_if.source                             rsp,
    input  wire logic                             cfg_we,
    input  wire logic [phd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [phd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic              push;
    logic              pop;
    logic              queue_full;
    logic              queue_empty;
    logic              init_busy;
    phd_pkg::phd_job_t push_job;
    phd_pkg::phd_job_t head;

    phd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .init_busy  (init_busy),
        .queue_full (queue_full),
        .push       (push),
        .job        (push_job)
    );

    phd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (queue_full),
        .empty    (queue_empty),
        .head     (head)
    );

    phd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .init_busy   (init_busy),
        .rsp         (rsp)
    );

endmodule

`default_nettype wire
